/* rtl/four_digit_segment_scanner_defines.svh */
// ----------------------------------------------------------------------------
// Four digit segment scanner - assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef FOUR_DIGIT_SEGMENT_SCANNER_DEFINES_SVH
`define FOUR_DIGIT_SEGMENT_SCANNER_DEFINES_SVH

// Property holds at every clock edge outside reset
`define FSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the following cycle
`define FSC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/fsc_pkg.sv */
// ----------------------------------------------------------------------------
// fsc_pkg
// Types, constants and lookup functions shared by the segment scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsc_pkg;

  localparam int unsigned TimeWidthDefault = 32;
  localparam int unsigned ValueWidth       = 16;
  localparam int unsigned PeriodWidth      = 8;
  localparam logic [PeriodWidth-1:0] PeriodReset = 8'd5;

  // Decoupling queue between front and back
  localparam int unsigned FifoDepth = 2;

  // Reciprocal divide: quotient = (value * recip) >> RecipShift, exact for 16-bit values
  localparam int unsigned RecipShift = 26;
  localparam int unsigned RecipWidth = 27;
  localparam int unsigned ProdWidth  = ValueWidth + RecipWidth;

  // Divide by ten: (q * Div10Mul) >> Div10Shift, exact for 16-bit q
  localparam int unsigned Div10Width = 16;
  localparam logic [Div10Width-1:0] Div10Mul = 16'd52429;
  localparam int unsigned Div10Shift = 19;
  localparam int unsigned Q10Width   = 2 * Div10Width - Div10Shift;

  localparam logic [3:0] BinaryBase = 4'd10;
  localparam logic [7:0] PointOff   = 8'h08;
  localparam logic [7:0] BlankSeg   = 8'hFF;

  typedef enum logic [0:0] {
    MODE_DECIMAL = 1'b0,
    MODE_BINARY  = 1'b1
  } mode_e;

  // One queued tick, already classified by the front
  typedef struct packed {
    logic [ValueWidth-1:0] value;
    mode_e                 mode;
    logic                  switched;
    logic [1:0]            pos;
  } fsc_entry_t;

  // Reciprocal of the place value for each digit position
  function automatic logic [RecipWidth-1:0] place_recip(input logic [1:0] pos);
    logic [RecipWidth-1:0] r;
    unique case (pos)
      2'd0: r = 27'd67109;     // thousands
      2'd1: r = 27'd671089;    // hundreds
      2'd2: r = 27'd6710887;   // tens
      2'd3: r = 27'd67108864;  // units
    endcase
    return r;
  endfunction

  // Segment word table (active high)
  function automatic logic [7:0] seg_word(input logic [3:0] idx);
    logic [7:0] w;
    unique case (idx)
      4'd0:    w = 8'hF3;
      4'd1:    w = 8'h60;
      4'd2:    w = 8'hB5;
      4'd3:    w = 8'hF4;
      4'd4:    w = 8'h66;
      4'd5:    w = 8'hD6;
      4'd6:    w = 8'hDF;
      4'd7:    w = 8'h70;
      4'd8:    w = 8'hFF;
      4'd9:    w = 8'hF6;
      4'd10:   w = 8'h00;
      4'd11:   w = 8'h40;
      4'd12:   w = 8'h01;
      4'd13:   w = 8'h41;
      default: w = 8'h00;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/fsc_front.sv */
// ----------------------------------------------------------------------------
// fsc_front
// Tick counter, deadline compare and digit sequencing; classifies each tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsc_front
  import fsc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TimeWidthDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [PeriodWidth-1:0] cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [ValueWidth-1:0]  value_i,
  input  wire logic                   mode_i,
  output logic                        push_valid_o,
  input  wire logic                   push_ready_i,
  output fsc_entry_t                  push_data_o
);

  logic [PeriodWidth-1:0] period_q;
  logic [TIME_WIDTH-1:0]  tick_q, tick_d;
  logic [TIME_WIDTH-1:0]  deadline_q, deadline_d;
  logic [1:0]             digit_q, digit_d;
  logic                   accept;
  logic                   switch_now;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  // Counter advances first, then compares against the deadline
  always_comb begin
    tick_d     = tick_q + TIME_WIDTH'(1);
    switch_now = tick_d > deadline_q;
    deadline_d = tick_d + {{(TIME_WIDTH-PeriodWidth){1'b0}}, period_q};
    digit_d    = digit_q + 2'd1;
  end

  // Classified entry towards the queue
  always_comb begin
    push_valid_o          = in_valid_i;
    push_data_o.value     = value_i;
    push_data_o.mode      = mode_e'(mode_i);
    push_data_o.switched  = switch_now;
    push_data_o.pos       = digit_q;
  end

  // Refresh period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  // Timing state, updated on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      deadline_q <= '0;
      digit_q    <= '0;
    end else if (accept) begin
      tick_q <= tick_d;
      if (switch_now) begin
        deadline_q <= deadline_d;
        digit_q    <= digit_d;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/fsc_fifo.sv */
// ----------------------------------------------------------------------------
// fsc_fifo
// Short queue decoupling the front from the decode back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsc_fifo
  import fsc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_valid_i,
  output logic            push_ready_o,
  input  wire fsc_entry_t push_data_i,
  output logic            pop_valid_o,
  input  wire logic       pop_ready_i,
  output fsc_entry_t      pop_data_o
);

  localparam int unsigned PtrWidth = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntWidth = $clog2(FifoDepth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(FifoDepth - 1);

  fsc_entry_t            mem_q [FifoDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0]   count_q;
  logic                  push, pop;

  assign push_ready_o = count_q != CntWidth'(FifoDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrWidth'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrWidth'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntWidth'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntWidth'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/fsc_back.sv */
// ----------------------------------------------------------------------------
// fsc_back
// Digit extraction, segment lookup, held display state and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "four_digit_segment_scanner_defines.svh"

module fsc_back
  import fsc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       pop_valid_i,
  output logic            pop_ready_o,
  input  wire fsc_entry_t pop_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      digit_enable_o,
  output logic [7:0]      segments_o,
  output logic            refreshed_o
);

  // Stage 1: place-value quotient
  logic                  s1_valid_q;
  logic [ValueWidth-1:0] s1_quot_q;
  mode_e                 s1_mode_q;
  logic [1:0]            s1_grp_q;
  logic [1:0]            s1_pos_q;
  logic                  s1_sw_q;

  // Stage 2: quotient divided by ten
  logic                  s2_valid_q;
  logic [ValueWidth-1:0] s2_quot_q;
  logic [Q10Width-1:0]   s2_q10_q;
  mode_e                 s2_mode_q;
  logic [1:0]            s2_grp_q;
  logic [1:0]            s2_pos_q;
  logic                  s2_sw_q;

  // Output register and held display
  logic       out_valid_q;
  logic [3:0] enable_q, enable_d;
  logic [7:0] segments_q, segments_d;
  logic       refreshed_q;

  logic                   advance;
  logic [ProdWidth-1:0]   prod1;
  logic [1:0]             grp;
  logic [2*Div10Width-1:0] prod2;
  logic [3:0]             q10x10;
  logic [3:0]             digit;
  logic [3:0]             tbl_idx;

  // Whole pipeline moves when the output slot frees up
  assign advance     = !out_valid_q || out_ready_i;
  assign pop_ready_o = advance;

  // Stage 1 logic
  always_comb begin
    prod1 = ProdWidth'(pop_data_i.value) * ProdWidth'(place_recip(pop_data_i.pos));
    unique case (pop_data_i.pos)
      2'd0: grp = pop_data_i.value[7:6];
      2'd1: grp = pop_data_i.value[5:4];
      2'd2: grp = pop_data_i.value[3:2];
      2'd3: grp = pop_data_i.value[1:0];
    endcase
  end

  // Stage 2 logic
  assign prod2 = {{Div10Width{1'b0}}, s1_quot_q} * {{Div10Width{1'b0}}, Div10Mul};

  // Final digit, table lookup and held state
  always_comb begin
    q10x10  = s2_q10_q[3:0] * 4'd10;
    digit   = s2_quot_q[3:0] - q10x10;
    tbl_idx = (s2_mode_q == MODE_BINARY) ? (BinaryBase + {2'b00, s2_grp_q}) : digit;
    enable_d   = enable_q;
    segments_d = segments_q;
    if (s2_valid_q && s2_sw_q) begin
      enable_d   = 4'b0001 << s2_pos_q;
      segments_d = ~seg_word(tbl_idx) | PointOff;
    end
  end

  // Pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      enable_q    <= '0;
      segments_q  <= BlankSeg;
      refreshed_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= pop_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
      enable_q    <= enable_d;
      segments_q  <= segments_d;
      refreshed_q <= s2_valid_q && s2_sw_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_quot_q <= prod1[RecipShift +: ValueWidth];
      s1_mode_q <= pop_data_i.mode;
      s1_grp_q  <= grp;
      s1_pos_q  <= pop_data_i.pos;
      s1_sw_q   <= pop_data_i.switched;
      s2_quot_q <= s1_quot_q;
      s2_q10_q  <= prod2[Div10Shift +: Q10Width];
      s2_mode_q <= s1_mode_q;
      s2_grp_q  <= s1_grp_q;
      s2_pos_q  <= s1_pos_q;
      s2_sw_q   <= s1_sw_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign digit_enable_o = enable_q;
  assign segments_o     = segments_q;
  assign refreshed_o    = refreshed_q;

  // Checks
  `FSC_ASSERT(a_enable_onehot0, $onehot0(enable_q), "digit enable not one-hot or zero")
  `FSC_ASSERT(a_point_off, segments_q[3], "decimal point segment driven")
  `FSC_ASSERT(a_refresh_enable, !(out_valid_q && refreshed_q) || (enable_q != 4'b0000),
              "refresh reported with no digit enabled")
  `FSC_ASSERT_NEXT(a_stage_to_out, s2_valid_q && advance, out_valid_q,
                   "decoded item lost before output register")

endmodule

`default_nettype wire

/* rtl/four_digit_segment_scanner.sv */
// ----------------------------------------------------------------------------
// four_digit_segment_scanner
// Throughput: one tick per cycle; back end and queue stall only on out_ready_i.
// Path: a result passes through the queue slot, quotient stage, divide-by-ten
// stage and output register before it shows on the outputs.
// Reset: asynchronous, active low; period 5, counters zero, display blank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module four_digit_segment_scanner
  import fsc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TimeWidthDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [PeriodWidth-1:0] cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [ValueWidth-1:0]  value_i,
  input  wire logic                   mode_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [3:0]                  digit_enable_o,
  output logic [7:0]                  segments_o,
  output logic                        refreshed_o
);

  logic       push_valid, push_ready;
  fsc_entry_t push_data;
  logic       pop_valid, pop_ready;
  fsc_entry_t pop_data;

  // Front: timing and classification
  fsc_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .mode_i       (mode_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decoupling queue
  fsc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back: decode and display hold
  fsc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_data_i     (pop_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digit_enable_o (digit_enable_o),
    .segments_o     (segments_o),
    .refreshed_o    (refreshed_o)
  );

endmodule

`default_nettype wire

/* test/four_digit_segment_scanner_tb.sv */
// ----------------------------------------------------------------------------
// four_digit_segment_scanner_tb
// Self-checking bench for the four digit segment scanner. A scoreboard keeps
// its own copy of the tick counter, deadline and digit state, forms the
// expected display frame for every tick transfer and checks each frame that
// leaves the block. Directed ticks come first, then random ticks under
// varying back-pressure and refresh periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_digit_segment_scanner_tb;
  import fsc_pkg::*;

  // Narrow tick counter for the bench
  localparam int unsigned TickBits     = 16;
  localparam int          QuietLimit   = 2000;
  localparam int          SettleCycles = 8;

  localparam logic [9:0][ValueWidth-1:0] DecimalCases = {
    16'd3210, 16'd10000, 16'd8901, 16'd4567, 16'd9090,
    16'd5678, 16'd1234,  16'd9999, 16'd65535, 16'd0
  };
  localparam logic [9:0][ValueWidth-1:0] BinaryCases = {
    16'h0039, 16'h00C6, 16'h1239, 16'h0055, 16'h00AA,
    16'hFF00, 16'h001B, 16'h00E4, 16'hFFFF, 16'h0000
  };

  typedef struct packed {
    logic [3:0] enables;
    logic [7:0] segments;
    logic       refreshed;
  } display_frame_t;

  // Scoreboard: display state of the scanner plus frames still owed
  class display_scoreboard;
    logic [TickBits-1:0]    ticks;
    logic [TickBits-1:0]    due;
    logic [1:0]             slot;
    logic [3:0]             enables;
    logic [7:0]             pattern;
    logic [PeriodWidth-1:0] period;
    display_frame_t         expected_frames[$];
    int                     fails;

    function new();
      ticks      = '0;
      due        = '0;
      slot       = 2'd0;
      enables    = 4'd0;
      pattern    = 8'hFF;
      period     = 8'd5;
      fails      = 0;
    endfunction

    // Active-high segment words: digits 0-9, then the four binary pairs
    function logic [7:0] glyph(int unsigned code);
      logic [7:0] w;
      case (code)
        0:       w = 8'hF3;
        1:       w = 8'h60;
        2:       w = 8'hB5;
        3:       w = 8'hF4;
        4:       w = 8'h66;
        5:       w = 8'hD6;
        6:       w = 8'hDF;
        7:       w = 8'h70;
        8:       w = 8'hFF;
        9:       w = 8'hF6;
        10:      w = 8'h00;
        11:      w = 8'h40;
        12:      w = 8'h01;
        default: w = 8'h41;
      endcase
      return w;
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    // One tick transfer: bump the counter, switch digit once past the deadline
    function void note_tick(logic [ValueWidth-1:0] v, mode_e m);
      display_frame_t f;
      int unsigned    n;
      int unsigned    code;
      n = 32'(v);
      ticks = ticks + 1'b1;
      f.refreshed = 1'b0;
      if (ticks > due) begin
        if (m == MODE_BINARY) begin
          code = 10 + ((n >> (6 - 2 * int'(slot))) & 3);
        end else begin
          case (slot)
            2'd0:    code = (n / 1000) % 10;
            2'd1:    code = (n / 100) % 10;
            2'd2:    code = (n / 10) % 10;
            default: code = n % 10;
          endcase
        end
        enables     = 4'b0001 << slot;
        pattern     = ~glyph(code) | PointOff;
        slot        = slot + 2'd1;
        due         = ticks + period;
        f.refreshed = 1'b1;
      end
      f.enables  = enables;
      f.segments = pattern;
      expected_frames.push_back(f);
    endfunction

    // One frame transfer, compared against the oldest owed frame
    function void check_frame(logic [3:0] en, logic [7:0] seg, logic rf);
      display_frame_t want;
      if (expected_frames.size() == 0) begin
        fails++;
        $error("frame with no tick outstanding: digit_enable %h segments %h", en, seg);
        return;
      end
      want = expected_frames.pop_front();
      if (en !== want.enables) begin
        fails++;
        $error("digit_enable: expected %h, got %h", want.enables, en);
      end
      if (seg !== want.segments) begin
        fails++;
        $error("segments: expected %h, got %h", want.segments, seg);
      end
      if (rf !== want.refreshed) begin
        fails++;
        $error("refreshed: expected %b, got %b", want.refreshed, rf);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [PeriodWidth-1:0] cfg_wdata;
  logic                   in_valid;
  logic                   in_ready;
  logic [ValueWidth-1:0]  value_q;
  mode_e                  mode_q;
  logic                   out_valid;
  logic                   out_ready;
  logic [3:0]             digit_enable;
  logic [7:0]             segments;
  logic                   refreshed;

  int src_idle_pct;
  int sink_idle_pct;
  int quiet_cycles;

  display_scoreboard sb;

  four_digit_segment_scanner #(
    .TIME_WIDTH(TickBits)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .value_i       (value_q),
    .mode_i        (mode_q),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .digit_enable_o(digit_enable),
    .segments_o    (segments),
    .refreshed_o   (refreshed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Monitor both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_tick(value_q, mode_q);
      if (out_valid && out_ready) sb.check_frame(digit_enable, segments, refreshed);
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one tick; valid stays high until the transfer
  task automatic send_tick(input logic [ValueWidth-1:0] v, input mode_e m);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value_q  <= v;
    mode_q   <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Wait for every owed frame, then let the pipeline settle
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_period(input logic [PeriodWidth-1:0] p);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    sb.period = p;
    cfg_we    <= 1'b0;
  endtask

  // Mix of full-range, four-digit and corner values
  function automatic logic [ValueWidth-1:0] pick_value();
    logic [ValueWidth-1:0] r;
    r = ValueWidth'($urandom);
    case ($urandom_range(3))
      0: r = ValueWidth'($urandom_range(9999));
      1: begin
        case ($urandom_range(5))
          0:       r = 16'd0;
          1:       r = 16'hFFFF;
          2:       r = 16'd9999;
          3:       r = 16'd10000;
          4:       r = 16'h00FF;
          default: r = ValueWidth'(1000 * $urandom_range(9));
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_tick(pick_value(), mode_e'($urandom_range(1)));
  endtask

  initial begin
    sb = new();
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    value_q       <= '0;
    mode_q        <= MODE_DECIMAL;
    out_ready     <= 1'b0;
    quiet_cycles  = 0;
    src_idle_pct  = 37;
    sink_idle_pct = 80;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset period: the first tick switches to the thousands digit, then hold
    send_tick(16'd4321, MODE_DECIMAL);
    send_tick(16'd4321, MODE_DECIMAL);
    send_tick(16'h00E4, MODE_BINARY);
    send_tick(16'h00E4, MODE_BINARY);
    drain_and_settle();

    // Zero period: once past the old deadline every tick switches, so each later case lands on a new digit
    write_period(8'd0);
    for (int i = 0; i < 10; i++) send_tick(DecimalCases[i], MODE_DECIMAL);
    for (int i = 0; i < 10; i++) send_tick(BinaryCases[i], MODE_BINARY);

    send_random(200);
    drain_and_settle();

    // Sender mostly idle, receiver mostly ready
    src_idle_pct  = 80;
    sink_idle_pct = 37;
    write_period(8'd3);
    send_random(200);
    drain_and_settle();

    // Full rate from here on; longest period first
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_period(8'hFF);
    send_random(150);
    drain_and_settle();

    write_period(8'd1);
    send_random(50);
    drain_and_settle();

    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
